>>> sv/plt_pkg.sv
// shared constants and types for the path length and travel time block
package plt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int SPEED_W     = 32;
  localparam int SUM_W       = 48;
  localparam int EFF_W       = 40;
  localparam int FRAC_W      = 16;

  // sum of three squares and its root
  localparam int SQ_W  = 2 * COORD_WIDTH + 2;
  localparam int LEN_W = COORD_WIDTH + 1;

  // divider: segment time and efficiency share one unit
  localparam int SEG_DVD_W = LEN_W + FRAC_W;
  localparam int EFF_DVD_W = SUM_W + FRAC_W;
  localparam int DIV_W     = (SEG_DVD_W > EFF_DVD_W) ? SEG_DVD_W : EFF_DVD_W;
  localparam int DVS_W     = SUM_W;
  localparam int DSTEP_W   = $clog2(DIV_W + 1);

  localparam int ADD_W = ((LEN_W > SUM_W) ? LEN_W : SUM_W) + 1;

  localparam int IN_FIELDS_W  = 3 * COORD_WIDTH + SPEED_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * SUM_W + EFF_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [EFF_W-1:0] EFF_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_SEG_DIV,
    ST_FINISH,
    ST_EFF_DIV,
    ST_EMIT
  } plt_state_t;

endpackage

>>> sv/plt_sqsum.sv
// bit-serial sum of three squares, one multiplier bit per cycle
module plt_sqsum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [plt_pkg::COORD_WIDTH-1:0]  ax,
  input  logic [plt_pkg::COORD_WIDTH-1:0]  ay,
  input  logic [plt_pkg::COORD_WIDTH-1:0]  az,
  output logic                             done,
  output logic [plt_pkg::SQ_W-1:0]         sq
);

  localparam int CW    = plt_pkg::COORD_WIDTH;
  localparam int CNT_W = $clog2(CW + 1);

  logic [CW-1:0]    mx_r, my_r, mz_r;
  logic [CW-1:0]    sx_r, sy_r, sz_r;
  logic [CW+1:0]    hi_r;
  logic [CW-1:0]    lo_r;
  logic [CW+2:0]    acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  // add the three selected multiplicands into the high half, then shift right
  always_comb begin
    acc_nxt = {1'b0, hi_r}
            + (sx_r[0] ? {3'b000, mx_r} : '0)
            + (sy_r[0] ? {3'b000, my_r} : '0)
            + (sz_r[0] ? {3'b000, mz_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(CW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx_r <= ax;
      my_r <= ay;
      mz_r <= az;
      sx_r <= ax;
      sy_r <= ay;
      sz_r <= az;
      hi_r <= '0;
      lo_r <= '0;
    end else if (run_r) begin
      hi_r <= acc_nxt[CW+2:1];
      lo_r <= {acc_nxt[0], lo_r[CW-1:1]};
      sx_r <= sx_r >> 1;
      sy_r <= sy_r >> 1;
      sz_r <= sz_r >> 1;
    end
  end

  assign sq   = {hi_r, lo_r};
  assign done = done_r;

endmodule

>>> sv/plt_sqrt.sv
// restoring integer square root, one root bit per cycle
module plt_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [plt_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [plt_pkg::LEN_W-1:0]   root
);

  localparam int RW    = plt_pkg::SQ_W;
  localparam int LW    = plt_pkg::LEN_W;
  localparam int REM_W = LW + 3;
  localparam int CNT_W = $clog2(LW + 1);

  logic [RW-1:0]    rad_r;
  logic [LW-1:0]    root_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] shifted_nxt;
  logic [REM_W-1:0] trial_nxt;
  logic             take_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    shifted_nxt = {rem_r[REM_W-3:0], rad_r[RW-1:RW-2]};
    trial_nxt   = {1'b0, root_r, 2'b01};
    take_nxt    = (shifted_nxt >= trial_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(LW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      root_r <= {root_r[LW-2:0], take_nxt};
      rem_r  <= take_nxt ? (shifted_nxt - trial_nxt) : shifted_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

>>> sv/plt_div.sv
// restoring divider, one quotient bit per cycle, dividend given left aligned
module plt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plt_pkg::DSTEP_W-1:0]   steps,
  input  logic [plt_pkg::DIV_W-1:0]     dividend,
  input  logic [plt_pkg::DVS_W-1:0]     divisor,
  output logic                          done,
  output logic [plt_pkg::DIV_W-1:0]     quotient
);

  localparam int DW    = plt_pkg::DIV_W;
  localparam int VW    = plt_pkg::DVS_W;
  localparam int CNT_W = plt_pkg::DSTEP_W;

  logic [DW-1:0]    dvd_r;
  logic [VW-1:0]    dvs_r;
  logic [VW-1:0]    rem_r;
  logic [VW:0]      shifted_nxt;
  logic [VW:0]      diff_nxt;
  logic             take_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  always_comb begin
    shifted_nxt = {rem_r, dvd_r[DW-1]};
    diff_nxt    = shifted_nxt - {1'b0, dvs_r};
    take_nxt    = (shifted_nxt >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= steps;
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) run_r <= 1'b0;
      end
    end
  end

  // quotient bits enter at the bottom as the dividend leaves at the top
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DW-2:0], take_nxt};
      rem_r <= take_nxt ? diff_nxt[VW-1:0] : shifted_nxt[VW-1:0];
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

>>> sv/path_length_and_travel_time.sv
// top level: path length, travel time and efficiency over a stream of points
//
//  channel | dir | tdata (lowest bit up)                              | tlast
//  in_     | in  | point_x, point_y, point_z, point_speed             | path_end
//  out_    | out | path_distance, path_time, path_efficiency          | -
//
// a point after the first runs square, root and divider in turn when the previous point's
// speed is positive, and square and root only otherwise
// the last point of a path adds the efficiency division when the path time is nonzero
// the first point of a path is only stored, with no square, root or division
// synchronous active-low reset clears sums, the have-previous-point flag and the output valid
// a stalled output holds only the last point of the next path; earlier points go on
module path_length_and_travel_time (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [plt_pkg::IN_DATA_W-1:0]     in_tdata,   // point_x, point_y, point_z, point_speed
  input  logic                              in_tlast,   // path_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [plt_pkg::OUT_DATA_W-1:0]    out_tdata   // path_distance, path_time, path_efficiency
);

  localparam int CW  = plt_pkg::COORD_WIDTH;
  localparam int SW  = plt_pkg::SPEED_W;
  localparam int UW  = plt_pkg::SUM_W;
  localparam int EW  = plt_pkg::EFF_W;
  localparam int FW  = plt_pkg::FRAC_W;
  localparam int DW  = plt_pkg::DIV_W;
  localparam int AW  = plt_pkg::ADD_W;

  plt_pkg::plt_state_t state_r, state_nxt;

  logic [CW-1:0] pt_x, pt_y, pt_z;
  logic [SW-1:0] pt_speed;
  logic          accept;
  logic          emit;

  logic [CW-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic [SW-1:0] prev_speed_r;
  logic [SW-1:0] seg_speed_r;
  logic          have_prev_r;
  logic          last_r;
  logic          speed_pos;

  logic [UW-1:0] dist_r, time_r;
  logic [EW-1:0] eff_r;
  logic          out_valid_r;
  logic [plt_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                          sq_start, sq_done;
  logic [plt_pkg::SQ_W-1:0]      sq_sum;
  logic                          root_start, root_done;
  logic [plt_pkg::LEN_W-1:0]     seg_len;
  logic                          div_start, div_done, div_eff;
  logic [plt_pkg::DSTEP_W-1:0]   div_steps;
  logic [DW-1:0]                 div_dvd, div_quot;
  logic [plt_pkg::DVS_W-1:0]     div_dvs;

  logic [AW-1:0] dist_add;
  logic [UW-1:0] dist_sat;
  logic [UW-1:0] seg_time;
  logic [UW:0]   time_add;
  logic [UW-1:0] time_sat;
  logic [EW-1:0] eff_sat;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    return d[CW] ? CW'(-d) : d[CW-1:0];
  endfunction

  assign pt_x     = in_tdata[CW-1:0];
  assign pt_y     = in_tdata[2*CW-1:CW];
  assign pt_z     = in_tdata[3*CW-1:2*CW];
  assign pt_speed = in_tdata[3*CW+SW-1:3*CW];

  assign accept    = in_tvalid && in_tready;
  assign emit      = (state_r == plt_pkg::ST_EMIT) && (!out_valid_r || out_tready);
  assign speed_pos = (seg_speed_r != '0) && !seg_speed_r[SW-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plt_pkg::ST_IDLE: begin
        if (accept) state_nxt = have_prev_r ? plt_pkg::ST_SQ : plt_pkg::ST_FINISH;
      end
      plt_pkg::ST_SQ: begin
        if (sq_done) state_nxt = plt_pkg::ST_ROOT;
      end
      plt_pkg::ST_ROOT: begin
        if (root_done) state_nxt = speed_pos ? plt_pkg::ST_SEG_DIV : plt_pkg::ST_FINISH;
      end
      plt_pkg::ST_SEG_DIV: begin
        if (div_done) state_nxt = plt_pkg::ST_FINISH;
      end
      plt_pkg::ST_FINISH: begin
        if (!last_r) state_nxt = plt_pkg::ST_IDLE;
        else if (time_r != '0) state_nxt = plt_pkg::ST_EFF_DIV;
        else state_nxt = plt_pkg::ST_EMIT;
      end
      plt_pkg::ST_EFF_DIV: begin
        if (div_done) state_nxt = plt_pkg::ST_EMIT;
      end
      plt_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = plt_pkg::ST_IDLE;
      end
      default: state_nxt = plt_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    in_tready  = 1'b0;
    sq_start   = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    div_eff    = 1'b0;
    unique case (state_r) inside
      plt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        sq_start  = in_tvalid && have_prev_r;
      end
      plt_pkg::ST_SQ: begin
        root_start = sq_done;
      end
      plt_pkg::ST_ROOT: begin
        div_start = root_done && speed_pos;
      end
      plt_pkg::ST_FINISH: begin
        div_eff   = 1'b1;
        div_start = last_r && (time_r != '0);
      end
      plt_pkg::ST_SEG_DIV, plt_pkg::ST_EFF_DIV, plt_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // divider operands, dividends left aligned so the quotient lands at the bottom
  always_comb begin
    if (div_eff) begin
      div_dvd   = DW'({dist_r, {FW{1'b0}}}) << (DW - plt_pkg::EFF_DVD_W);
      div_dvs   = time_r;
      div_steps = plt_pkg::DSTEP_W'(plt_pkg::EFF_DVD_W);
    end else begin
      div_dvd   = DW'({seg_len, {FW{1'b0}}}) << (DW - plt_pkg::SEG_DVD_W);
      div_dvs   = plt_pkg::DVS_W'(seg_speed_r[SW-2:0]);
      div_steps = plt_pkg::DSTEP_W'(plt_pkg::SEG_DVD_W);
    end
  end

  // saturating sums, segment time and efficiency
  always_comb begin
    dist_add = AW'(dist_r) + AW'(seg_len);
    dist_sat = (dist_add > AW'(plt_pkg::SUM_MAX)) ? plt_pkg::SUM_MAX : dist_add[UW-1:0];
    seg_time = (|div_quot[DW-1:UW]) ? plt_pkg::SUM_MAX : div_quot[UW-1:0];
    time_add = {1'b0, time_r} + {1'b0, seg_time};
    time_sat = time_add[UW] ? plt_pkg::SUM_MAX : time_add[UW-1:0];
    eff_sat  = (|div_quot[DW-1:EW]) ? plt_pkg::EFF_MAX : div_quot[EW-1:0];
  end

  plt_sqsum u_sqsum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .ax    (abs_diff(pt_x, prev_x_r)),
    .ay    (abs_diff(pt_y, prev_y_r)),
    .az    (abs_diff(pt_z, prev_z_r)),
    .done  (sq_done),
    .sq    (sq_sum)
  );

  plt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sq_sum),
    .done     (root_done),
    .root     (seg_len)
  );

  plt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plt_pkg::ST_IDLE;
      have_prev_r <= 1'b0;
      dist_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) have_prev_r <= 1'b1;
      if ((state_r == plt_pkg::ST_ROOT) && root_done) dist_r <= dist_sat;
      if ((state_r == plt_pkg::ST_SEG_DIV) && div_done) time_r <= time_sat;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      // path done: result goes out and the path state starts over
      if (emit) begin
        have_prev_r <= 1'b0;
        dist_r      <= '0;
        time_r      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r     <= pt_x;
      prev_y_r     <= pt_y;
      prev_z_r     <= pt_z;
      prev_speed_r <= pt_speed;
      seg_speed_r  <= prev_speed_r;
      last_r       <= in_tlast;
    end
    if (state_r == plt_pkg::ST_FINISH) eff_r <= '0;
    if ((state_r == plt_pkg::ST_EFF_DIV) && div_done) eff_r <= eff_sat;
    if (emit) out_data_r <= plt_pkg::OUT_DATA_W'({eff_r, time_r, dist_r});
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// testbench for the path length and travel time block: point stream checked against a predictor
module tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_POINTS = 800;

  localparam int COORD_WIDTH = plt_pkg::COORD_WIDTH;
  localparam int SPEED_W     = plt_pkg::SPEED_W;
  localparam int SUM_W       = plt_pkg::SUM_W;
  localparam int EFF_W       = plt_pkg::EFF_W;
  localparam int FRAC_W      = plt_pkg::FRAC_W;
  localparam int IN_DATA_W   = plt_pkg::IN_DATA_W;
  localparam int OUT_DATA_W  = plt_pkg::OUT_DATA_W;
  localparam logic [SUM_W-1:0] SUM_MAX = plt_pkg::SUM_MAX;
  localparam logic [EFF_W-1:0] EFF_MAX = plt_pkg::EFF_MAX;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SPEED_W-1:0]     speed_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t C_MAX = ~C_MIN;
  localparam speed_t S_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam speed_t S_MAX = ~S_MIN;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    speed_t speed;
    logic   last;
  } point_t;

  typedef struct packed {
    logic [SUM_W-1:0] distance;
    logic [SUM_W-1:0] travel;
    logic [EFF_W-1:0] efficiency;
  } path_totals_t;

  typedef struct {
    point_t       pt;
    bit           typed;
    path_totals_t want;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state
  point_t           last_point;
  bit               have_point;
  logic [SUM_W-1:0] distance_acc;
  logic [SUM_W-1:0] travel_acc;

  path_totals_t pending_totals[$];
  stim_row_t    directed_rows[$];
  path_totals_t sink_got, sink_want;

  int     send_idle_pct, recv_idle_pct;
  int     mismatch_count, results_checked, points_sent, paths_sent;
  longint cycle_count;

  always #5 clk = ~clk;

  path_length_and_travel_time u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [COORD_WIDTH:0] abs_delta(coord_t a, coord_t b);
    logic signed [COORD_WIDTH:0] d;
    d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    return d[COORD_WIDTH] ? -d : d;
  endfunction

  // floor of the euclidean distance, exact
  function automatic logic [COORD_WIDTH+1:0] segment_length(point_t a, point_t b);
    logic [COORD_WIDTH:0]   dx, dy, dz;
    logic [127:0]           sumsq, cand;
    logic [COORD_WIDTH+1:0] root;
    dx = abs_delta(a.x, b.x);
    dy = abs_delta(a.y, b.y);
    dz = abs_delta(a.z, b.z);
    sumsq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
    root = '0;
    for (int i = COORD_WIDTH + 1; i >= 0; i--) begin
      cand = 128'(root) | (128'(1) << i);
      if (cand * cand <= sumsq) root = cand[COORD_WIDTH+1:0];
    end
    return root;
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [127:0] b);
    logic [127:0] s;
    s = 128'(a) + b;
    return (s > 128'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // updates the running sums; returns 1 with the totals when the point closes a path
  function automatic bit advance_path(point_t p, output path_totals_t t);
    logic [COORD_WIDTH+1:0] len;
    logic [127:0]           q;
    t = '0;
    if (have_point) begin
      len = segment_length(p, last_point);
      distance_acc = sat_sum(distance_acc, 128'(len));
      if (last_point.speed > 0)
        travel_acc = sat_sum(travel_acc,
                             (128'(len) << FRAC_W) / 128'($unsigned(last_point.speed)));
    end
    last_point = p;
    have_point = 1'b1;
    if (!p.last) return 1'b0;
    t.distance = distance_acc;
    t.travel   = travel_acc;
    if (travel_acc != '0) begin
      q = (128'(distance_acc) << FRAC_W) / 128'(travel_acc);
      t.efficiency = (q > 128'(EFF_MAX)) ? EFF_MAX : q[EFF_W-1:0];
    end
    last_point   = '0;
    have_point   = 1'b0;
    distance_acc = '0;
    travel_acc   = '0;
    return 1'b1;
  endfunction

  task automatic add_row(coord_t x, coord_t y, coord_t z, speed_t speed, bit last, bit typed,
                         logic [SUM_W-1:0] d, logic [SUM_W-1:0] t, logic [EFF_W-1:0] e);
    stim_row_t r;
    r.pt.x = x;
    r.pt.y = y;
    r.pt.z = z;
    r.pt.speed = speed;
    r.pt.last = last;
    r.typed = typed;
    r.want.distance = d;
    r.want.travel = t;
    r.want.efficiency = e;
    directed_rows = {directed_rows, r};
  endtask

  task automatic send_point(point_t p, bit typed, path_totals_t want);
    path_totals_t t;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.speed, p.z, p.y, p.x};
    in_tlast  <= p.last;
    do @(posedge clk); while (!in_tready);
    points_sent++;
    if (advance_path(p, t)) begin
      pending_totals = {pending_totals, (typed ? want : t)};
      paths_sent++;
    end
  endtask

  // hold the input until every outstanding total has come back
  task automatic wait_for_totals();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_totals.size() != 0);
  endtask

  function automatic coord_t corner_value();
    case ($urandom_range(4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic speed_t random_speed();
    case ($urandom_range(9)) inside
      0:       return '0;
      1:       return speed_t'($urandom | 32'h8000_0000);
      2:       return $urandom_range(1) ? speed_t'(1) : S_MAX;
      [3:4]:   return speed_t'($urandom_range(32'h7FFF_FFFF, 1));
      default: return speed_t'($urandom_range(65535, 1));
    endcase
  endfunction

  task automatic send_random_path();
    int     n, style;
    point_t p;
    coord_t bx, by, bz;
    n = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
    style = $urandom_range(3);
    bx = $urandom;
    by = $urandom;
    bz = $urandom;
    for (int k = 0; k < n; k++) begin
      case (style)
        0: begin
          p.x = $urandom;
          p.y = $urandom;
          p.z = $urandom;
        end
        1: begin
          // short hops around a wandering base
          bx = bx + coord_t'($urandom_range(8192)) - coord_t'(4096);
          by = by + coord_t'($urandom_range(8192)) - coord_t'(4096);
          bz = bz + coord_t'($urandom_range(8192)) - coord_t'(4096);
          p.x = bx;
          p.y = by;
          p.z = bz;
        end
        2: begin
          p.x = corner_value();
          p.y = corner_value();
          p.z = corner_value();
        end
        default: begin
          p.x = coord_t'($urandom_range(2048)) - coord_t'(1024);
          p.y = coord_t'($urandom_range(2048)) - coord_t'(1024);
          p.z = coord_t'($urandom_range(2048)) - coord_t'(1024);
        end
      endcase
      p.speed = random_speed();
      p.last  = (k == n - 1);
      send_point(p, 1'b0, '0);
    end
  endtask

  // result side: random backpressure and comparison against the oldest expected totals
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sink_got.distance   = out_tdata[SUM_W-1:0];
      sink_got.travel     = out_tdata[2*SUM_W-1:SUM_W];
      sink_got.efficiency = out_tdata[2*SUM_W+EFF_W-1:2*SUM_W];
      if (pending_totals.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual %h",
                 $time, out_tdata);
        mismatch_count++;
      end else begin
        sink_want = pending_totals.pop_front();
        results_checked++;
        if (sink_got.distance !== sink_want.distance) begin
          $display("%0t: path_distance expected %h actual %h",
                   $time, sink_want.distance, sink_got.distance);
          mismatch_count++;
        end
        if (sink_got.travel !== sink_want.travel) begin
          $display("%0t: path_time expected %h actual %h",
                   $time, sink_want.travel, sink_got.travel);
          mismatch_count++;
        end
        if (sink_got.efficiency !== sink_want.efficiency) begin
          $display("%0t: path_efficiency expected %h actual %h",
                   $time, sink_want.efficiency, sink_got.efficiency);
          mismatch_count++;
        end
      end
    end
    out_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ndir, phase, cur_phase;
    send_idle_pct = 36;
    recv_idle_pct = 58;
    cur_phase = 0;

    // lone point: no segment, all zeros
    add_row(5, 5, 5, 100, 1, 1, 0, 0, 0);
    // 3-4-5 segment at speed 5
    add_row(0, 0, 0, 5, 0, 0, 0, 0, 0);
    add_row(3, 4, 0, 0, 1, 1, 5, 65536, 5);
    // zero speed: length only, zero time gives zero efficiency
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 7, 9, 1, 1, 7, 0, 0);
    // negative speed skips the time as well
    add_row(0, 0, 0, -1, 0, 0, 0, 0, 0);
    add_row(0, 5, 0, 1, 1, 1, 5, 0, 0);
    // opposite corners of the coordinate range
    add_row(C_MIN, C_MIN, C_MIN, S_MAX, 0, 0, 0, 0, 0);
    add_row(C_MAX, C_MAX, C_MAX, S_MIN, 1, 0, 0, 0, 0);
    // speed 1 over huge segments saturates the time
    add_row(C_MIN, 0, C_MAX, 1, 0, 0, 0, 0, 0);
    add_row(C_MAX, 0, C_MIN, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 1, 1, 0, 0, 0, 0);
    // tiny time with a long untimed segment saturates efficiency
    add_row(0, 0, 0, S_MAX, 0, 0, 0, 0, 0);
    add_row(32768, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(C_MIN, 0, 0, 5, 1, 0, 0, 0, 0);
    // three-point path with plain numbers
    add_row(100, 200, 300, 256, 0, 0, 0, 0, 0);
    add_row(356, 200, 300, 512, 0, 0, 0, 0, 0);
    add_row(356, 712, 300, 256, 1, 1, 768, 131072, 384);
    ndir = directed_rows.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);

    while (points_sent < ndir + RANDOM_POINTS) begin
      phase = (points_sent - ndir) * 3 / RANDOM_POINTS;
      if (phase != cur_phase) begin
        wait_for_totals();
        cur_phase = phase;
        send_idle_pct = (phase == 1) ? 58 : 0;
        recv_idle_pct = (phase == 1) ? 36 : 0;
      end
      send_random_path();
    end

    wait_for_totals();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run sent %0d points in %0d paths and compared %0d totals",
             points_sent, paths_sent, results_checked);
    $display("directed corner paths first, then random paths under three stall mixes");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
